>>> src/sri_pkg.sv
// shared types, opcodes and helper functions for the scalar risc execute block
// no dependencies; used by every other file of the block except sri_if
package sri_pkg;

   localparam int DATA_MEM_BYTES = 4096;
   localparam int MEM_AW         = $clog2(DATA_MEM_BYTES);
   localparam int MEM_ROWS       = DATA_MEM_BYTES / 4;
   localparam int ROW_W          = $clog2(MEM_ROWS);

   localparam logic [31:0] JR_BASE   = 32'h0400_0000;
   localparam logic [31:0] JR_MASK   = 32'h0000_1fff;
   localparam logic [31:0] LINK_MASK = 32'h0000_ffff;
   localparam logic [4:0]  LINK_REG  = 5'h1f;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0a;
   localparam logic [5:0] OP_SLTIU   = 6'h0b;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_XORI    = 6'h0e;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_COP2    = 6'h12;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2b;
   localparam logic [5:0] OP_LWC2    = 6'h32;
   localparam logic [5:0] OP_SWC2    = 6'h3a;

   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_JALR  = 6'h09;
   localparam logic [5:0] FN_BREAK = 6'h0d;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLT   = 6'h2a;
   localparam logic [5:0] FN_SLTU  = 6'h2b;

   localparam logic [4:0] RI_BLTZ   = 5'h00;
   localparam logic [4:0] RI_BGEZ   = 5'h01;
   localparam logic [4:0] RI_BLTZAL = 5'h10;
   localparam logic [4:0] RI_BGEZAL = 5'h11;

   localparam logic [4:0] CP0_MF = 5'h00;
   localparam logic [4:0] CP0_MT = 5'h04;

   typedef enum logic [1:0] {
      SZ_BYTE = 2'd0,
      SZ_HALF = 2'd1,
      SZ_WORD = 2'd2
   } mem_size_type;

   typedef logic [3:0][7:0] lanes_type;

   typedef struct packed {
      logic         wr;
      logic [4:0]   dst;
      logic [31:0]  value;
      logic         br;
      logic [31:0]  tgt;
      logic         ill;
      logic         load;
      logic         load_signed;
      logic         store;
      mem_size_type size;
      logic [31:0]  ea;
      logic [31:0]  store_data;
   } exec_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic              en;
      mem_size_type      size;
      logic [MEM_AW-1:0] addr;
      logic [31:0]       data;
   } mem_wr_type;

   // index of the last byte of an access
   function automatic logic [1:0] size_last(mem_size_type size);
      logic [1:0] last;
      case (size)
         SZ_BYTE: last = 2'd0;
         SZ_HALF: last = 2'd1;
         SZ_WORD: last = 2'd3;
         default: last = 2'd0;
      endcase
      return last;
   endfunction

   // big-endian assembly of the bank bytes starting at lane off
   function automatic logic [31:0] load_value(lanes_type lanes, logic [1:0] off,
                                              mem_size_type size, logic sgn);
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [31:0] v;
      b0 = lanes[off];
      b1 = lanes[2'(off + 2'd1)];
      b2 = lanes[2'(off + 2'd2)];
      b3 = lanes[2'(off + 2'd3)];
      case (size)
         SZ_BYTE: v = {{24{sgn & b0[7]}}, b0};
         SZ_HALF: v = {{16{sgn & b0[7]}}, b0, b1};
         SZ_WORD: v = {b0, b1, b2, b3};
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> src/sri_if.sv
// request and response channel interfaces of the scalar risc execute block
// no dependencies
interface sri_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction_word;
   logic [31:0] instruction_address;

   modport source (output valid, output instruction_word, output instruction_address,
                   input ready);
   modport sink (input valid, input instruction_word, input instruction_address,
                 output ready);
endinterface

interface sri_rsp_if;
   logic        valid;
   logic        ready;
   logic        writes_register;
   logic [4:0]  dest_register;
   logic [31:0] dest_value;
   logic        branch_taken;
   logic [31:0] branch_target;
   logic        illegal_opcode;

   modport source (output valid, output writes_register, output dest_register,
                   output dest_value, output branch_taken, output branch_target,
                   output illegal_opcode, input ready);
   modport sink (input valid, input writes_register, input dest_register,
                 input dest_value, input branch_taken, input branch_target,
                 input illegal_opcode, output ready);
endinterface

>>> src/scalar_risc_instruction_execute.sv
// top level of the scalar risc execute block: two-register pipeline around execute
// depends on sri_pkg, sri_if, sri_regfile, sri_dmem and sri_exec
//
// Executes one 32-bit integer instruction per cycle when not stalled, against a
// 32-word register file and a byte data memory of sri_pkg::DATA_MEM_BYTES bytes.
// A request is taken into the execute register, its operands coming from the
// register file read ports in the same edge; decode, alu and address add are
// combinational, and the edge that moves the instruction on writes the response
// register and reads the four memory banks. A new request can be accepted in
// every cycle while the response channel is not stalled and the memory is not
// being cleared, also back to back with loads and stores, since the pending
// response is forwarded to the executing instruction. Register and memory writes
// take effect when the response is delivered. After reset the memory is cleared
// one row of four bytes per cycle, and req_ch.ready stays low until it is done.
module scalar_risc_instruction_execute (
   input logic      clock,
   input logic      reset,
   sri_req_if.sink   req_ch,
   sri_rsp_if.source rsp_ch
);

   logic        x_valid_ff;
   logic        x_valid_in;
   logic [31:0] x_instr_ff;
   logic [31:0] x_instr_in;
   logic [31:0] x_pc_ff;
   logic [31:0] x_pc_in;

   logic              y_valid_ff;
   logic              y_valid_in;
   sri_pkg::exec_type y_res_ff;
   sri_pkg::exec_type y_res_in;

   logic               accept;
   logic               y_ready;
   logic               x_move;
   logic               commit;
   logic               mem_busy;
   logic [4:0]         raddr_a;
   logic [4:0]         raddr_b;
   logic [31:0]        rf_a;
   logic [31:0]        rf_b;
   logic [31:0]        op_a;
   logic [31:0]        op_b;
   logic [31:0]        y_value;
   sri_pkg::lanes_type lanes;
   sri_pkg::exec_type  ex;
   sri_pkg::rf_wr_type rf_wr;
   sri_pkg::mem_wr_type mem_wr;

   assign y_ready      = !y_valid_ff || rsp_ch.ready;
   assign x_move       = x_valid_ff && y_ready;
   assign req_ch.ready = (!x_valid_ff || y_ready) && !mem_busy;
   assign accept       = req_ch.valid && req_ch.ready;
   assign commit       = y_valid_ff && rsp_ch.ready;

   // read for the request being taken, else re-read for the one held
   assign raddr_a = accept ? req_ch.instruction_word[25:21] : x_instr_ff[25:21];
   assign raddr_b = accept ? req_ch.instruction_word[20:16] : x_instr_ff[20:16];

   assign y_value = y_res_ff.load ?
                    sri_pkg::load_value(lanes, y_res_ff.ea[1:0], y_res_ff.size,
                                        y_res_ff.load_signed) :
                    y_res_ff.value;

   // forward the response not yet written back
   always_comb begin
      op_a = rf_a;
      op_b = rf_b;
      if (y_valid_ff && y_res_ff.wr && y_res_ff.dst == x_instr_ff[25:21]) begin
         op_a = y_value;
      end
      if (y_valid_ff && y_res_ff.wr && y_res_ff.dst == x_instr_ff[20:16]) begin
         op_b = y_value;
      end
   end

   always_comb begin
      rf_wr.en    = commit && y_res_ff.wr;
      rf_wr.addr  = y_res_ff.dst;
      rf_wr.data  = y_value;
      mem_wr.en   = commit && y_res_ff.store;
      mem_wr.size = y_res_ff.size;
      mem_wr.addr = y_res_ff.ea[sri_pkg::MEM_AW-1:0];
      mem_wr.data = y_res_ff.store_data;
   end

   sri_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .wr      (rf_wr),
      .rdata_a (rf_a),
      .rdata_b (rf_b)
   );

   sri_exec u_exec (
      .instr (x_instr_ff),
      .pc    (x_pc_ff),
      .a     (op_a),
      .b     (op_b),
      .ex    (ex)
   );

   sri_dmem u_dmem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (x_move),
      .rd_addr  (ex.ea[sri_pkg::MEM_AW-1:0]),
      .wr       (mem_wr),
      .rd_lanes (lanes),
      .busy     (mem_busy)
   );

   always_comb begin
      x_valid_in = x_valid_ff;
      x_instr_in = x_instr_ff;
      x_pc_in    = x_pc_ff;
      y_valid_in = y_valid_ff;
      y_res_in   = y_res_ff;
      if (req_ch.ready) begin
         x_valid_in = req_ch.valid;
         x_instr_in = req_ch.instruction_word;
         x_pc_in    = req_ch.instruction_address;
      end
      if (y_ready) begin
         y_valid_in = x_valid_ff;
         y_res_in   = ex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         y_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
         y_valid_ff <= y_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_instr_ff <= x_instr_in;
      x_pc_ff    <= x_pc_in;
      y_res_ff   <= y_res_in;
   end

   assign rsp_ch.valid           = y_valid_ff;
   assign rsp_ch.writes_register = y_res_ff.wr;
   assign rsp_ch.dest_register   = y_res_ff.dst;
   assign rsp_ch.dest_value      = y_value;
   assign rsp_ch.branch_taken    = y_res_ff.br;
   assign rsp_ch.branch_target   = y_res_ff.tgt;
   assign rsp_ch.illegal_opcode  = y_res_ff.ill;

endmodule

>>> src/sri_regfile.sv
// 32 x 32 general register file, two registered read ports, one write port
// depends on sri_pkg; unwritten entries read zero through per-entry valid bits
module sri_regfile (
   input  logic              clock,
   input  logic              reset,
   input  logic [4:0]        raddr_a,
   input  logic [4:0]        raddr_b,
   input  sri_pkg::rf_wr_type wr,
   output logic [31:0]       rdata_a,
   output logic [31:0]       rdata_b
);

   logic [31:0] regs_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] valid_in;
   logic [31:0] rdata_a_ff;
   logic [31:0] rdata_b_ff;
   logic [31:0] rdata_a_in;
   logic [31:0] rdata_b_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   // write-through on a same-cycle write
   always_comb begin
      if (wr.en && wr.addr == raddr_a) begin
         rdata_a_in = wr.data;
      end else begin
         rdata_a_in = valid_ff[raddr_a] ? regs_ff[raddr_a] : '0;
      end
      if (wr.en && wr.addr == raddr_b) begin
         rdata_b_in = wr.data;
      end else begin
         rdata_b_in = valid_ff[raddr_b] ? regs_ff[raddr_b] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.addr] <= wr.data;
      end
      rdata_a_ff <= rdata_a_in;
      rdata_b_ff <= rdata_b_in;
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

>>> src/sri_dmem.sv
// byte data memory in four interleaved byte banks, big-endian unaligned access
// depends on sri_pkg; clears every row after reset, one row per cycle
module sri_dmem (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [sri_pkg::MEM_AW-1:0] rd_addr,
   input  sri_pkg::mem_wr_type       wr,
   output sri_pkg::lanes_type        rd_lanes,
   output logic                      busy
);

   logic                      clr_busy_ff;
   logic                      clr_busy_in;
   logic [sri_pkg::ROW_W-1:0] clr_row_ff;
   logic [sri_pkg::ROW_W-1:0] clr_row_in;
   logic [1:0]                wr_last;

   assign wr_last = sri_pkg::size_last(wr.size);

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == sri_pkg::ROW_W'(sri_pkg::MEM_ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [7:0]                 mem_ff [sri_pkg::MEM_ROWS];
      logic [7:0]                 rd_byte_ff;
      logic [7:0]                 rd_byte_in;
      logic [1:0]                 rd_lane;
      logic [sri_pkg::MEM_AW-1:0] rd_byte_addr;
      logic [sri_pkg::ROW_W-1:0]  rd_row;
      logic [1:0]                 wr_lane;
      logic [1:0]                 wr_shift;
      logic [sri_pkg::MEM_AW-1:0] wr_byte_addr;
      logic                       bank_we;
      logic [sri_pkg::ROW_W-1:0]  bank_row;
      logic [7:0]                 bank_data;

      // which byte of the access lands in this bank
      assign rd_lane      = 2'(j) - rd_addr[1:0];
      assign rd_byte_addr = rd_addr + sri_pkg::MEM_AW'(rd_lane);
      assign rd_row       = rd_byte_addr[sri_pkg::MEM_AW-1:2];

      assign wr_lane      = 2'(j) - wr.addr[1:0];
      assign wr_byte_addr = wr.addr + sri_pkg::MEM_AW'(wr_lane);
      assign wr_shift     = wr_last - wr_lane;

      always_comb begin
         if (clr_busy_ff) begin
            bank_we   = 1'b1;
            bank_row  = clr_row_ff;
            bank_data = '0;
         end else begin
            bank_we   = wr.en && (wr_lane <= wr_last);
            bank_row  = wr_byte_addr[sri_pkg::MEM_AW-1:2];
            bank_data = 8'(wr.data >> {wr_shift, 3'b000});
         end
      end

      always_comb begin
         if (bank_we && bank_row == rd_row) begin
            rd_byte_in = bank_data;
         end else begin
            rd_byte_in = mem_ff[rd_row];
         end
      end

      always_ff @(posedge clock) begin
         if (bank_we) begin
            mem_ff[bank_row] <= bank_data;
         end
         if (rd_en) begin
            rd_byte_ff <= rd_byte_in;
         end
      end

      assign rd_lanes[j] = rd_byte_ff;
   end

   assign busy = clr_busy_ff;

endmodule

>>> src/sri_exec.sv
// instruction decode and execute: alu, shifts, compares, branches, jumps, address
// depends on sri_pkg; purely combinational
module sri_exec (
   input  logic [31:0]       instr,
   input  logic [31:0]       pc,
   input  logic [31:0]       a,
   input  logic [31:0]       b,
   output sri_pkg::exec_type ex
);

   logic [5:0]  op;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sa;
   logic [5:0]  fn;
   logic [15:0] imm;
   logic [31:0] simm;
   logic [31:0] link;
   logic [31:0] btgt;
   logic [31:0] jtgt;
   logic [31:0] rtgt;
   logic        neg;

   logic                  wr;
   logic [4:0]            dst;
   logic [31:0]           val;
   logic                  br;
   logic [31:0]           tgt;
   logic                  ill;
   logic                  load;
   logic                  lsig;
   logic                  store;
   sri_pkg::mem_size_type size;

   assign op   = instr[31:26];
   assign rs   = instr[25:21];
   assign rt   = instr[20:16];
   assign rd   = instr[15:11];
   assign sa   = instr[10:6];
   assign fn   = instr[5:0];
   assign imm  = instr[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign link = pc + 32'd8;
   assign btgt = pc + {simm[29:0], 2'b00} + 32'd4;
   assign jtgt = {4'b0000, instr[25:0], 2'b00};
   assign rtgt = sri_pkg::JR_BASE | (a & sri_pkg::JR_MASK);
   assign neg  = a[31];

   always_comb begin
      wr    = 1'b0;
      dst   = '0;
      val   = '0;
      br    = 1'b0;
      tgt   = '0;
      ill   = 1'b0;
      load  = 1'b0;
      lsig  = 1'b0;
      store = 1'b0;
      size  = sri_pkg::SZ_BYTE;
      unique case (op) inside
         sri_pkg::OP_SPECIAL: begin
            wr  = 1'b1;
            dst = rd;
            unique case (fn) inside
               sri_pkg::FN_SLL:  val = b << sa;
               sri_pkg::FN_SRL:  val = b >> sa;
               sri_pkg::FN_SRA:  val = $unsigned($signed(b) >>> sa);
               sri_pkg::FN_SLLV: val = b << a[4:0];
               sri_pkg::FN_SRLV: val = b >> a[4:0];
               sri_pkg::FN_SRAV: val = $unsigned($signed(b) >>> a[4:0]);
               sri_pkg::FN_JR: begin
                  wr  = 1'b0;
                  br  = 1'b1;
                  tgt = rtgt;
               end
               sri_pkg::FN_JALR: begin
                  br  = 1'b1;
                  tgt = rtgt;
                  val = link;
               end
               sri_pkg::FN_BREAK: wr = 1'b0;
               sri_pkg::FN_ADD, sri_pkg::FN_ADDU: val = a + b;
               sri_pkg::FN_SUB, sri_pkg::FN_SUBU: val = a - b;
               sri_pkg::FN_AND:  val = a & b;
               sri_pkg::FN_OR:   val = a | b;
               sri_pkg::FN_XOR:  val = a ^ b;
               sri_pkg::FN_NOR:  val = ~(a | b);
               sri_pkg::FN_SLT:  val = {31'b0, $signed(a) < $signed(b)};
               sri_pkg::FN_SLTU: val = {31'b0, a < b};
               default: begin
                  wr  = 1'b0;
                  ill = 1'b1;
               end
            endcase
         end
         sri_pkg::OP_REGIMM: begin
            tgt = btgt;
            unique case (rt)
               sri_pkg::RI_BLTZ: br = neg;
               sri_pkg::RI_BGEZ: br = !neg;
               sri_pkg::RI_BLTZAL: begin
                  br  = neg;
                  wr  = 1'b1;
                  dst = sri_pkg::LINK_REG;
                  val = link;
               end
               sri_pkg::RI_BGEZAL: begin
                  br  = !neg;
                  wr  = 1'b1;
                  dst = sri_pkg::LINK_REG;
                  val = link;
               end
               default: ill = 1'b1;
            endcase
         end
         sri_pkg::OP_J: begin
            br  = 1'b1;
            tgt = jtgt;
         end
         sri_pkg::OP_JAL: begin
            br  = 1'b1;
            tgt = jtgt;
            wr  = 1'b1;
            dst = sri_pkg::LINK_REG;
            val = link & sri_pkg::LINK_MASK;
         end
         sri_pkg::OP_BEQ: begin
            br  = (a == b);
            tgt = btgt;
         end
         sri_pkg::OP_BNE: begin
            br  = (a != b);
            tgt = btgt;
         end
         sri_pkg::OP_BLEZ: begin
            br  = (a == '0) || neg;
            tgt = btgt;
         end
         sri_pkg::OP_BGTZ: begin
            br  = (a != '0) && !neg;
            tgt = btgt;
         end
         sri_pkg::OP_ADDI, sri_pkg::OP_ADDIU: begin
            wr  = 1'b1;
            dst = rt;
            val = a + simm;
         end
         sri_pkg::OP_SLTI: begin
            wr  = 1'b1;
            dst = rt;
            val = {31'b0, $signed(a) < $signed(simm)};
         end
         sri_pkg::OP_SLTIU: begin
            wr  = 1'b1;
            dst = rt;
            val = {31'b0, a < simm};
         end
         sri_pkg::OP_ANDI: begin
            wr  = 1'b1;
            dst = rt;
            val = a & {16'b0, imm};
         end
         sri_pkg::OP_ORI: begin
            wr  = 1'b1;
            dst = rt;
            val = a | {16'b0, imm};
         end
         sri_pkg::OP_XORI: begin
            wr  = 1'b1;
            dst = rt;
            val = a ^ {16'b0, imm};
         end
         sri_pkg::OP_LUI: begin
            wr  = 1'b1;
            dst = rt;
            val = {imm, 16'b0};
         end
         sri_pkg::OP_COP0: ill = (rs != sri_pkg::CP0_MF) && (rs != sri_pkg::CP0_MT);
         sri_pkg::OP_COP2, sri_pkg::OP_LWC2, sri_pkg::OP_SWC2: begin
         end
         sri_pkg::OP_LB, sri_pkg::OP_LBU: begin
            wr   = 1'b1;
            dst  = rt;
            load = 1'b1;
            lsig = (op == sri_pkg::OP_LB);
            size = sri_pkg::SZ_BYTE;
         end
         sri_pkg::OP_LH, sri_pkg::OP_LHU: begin
            wr   = 1'b1;
            dst  = rt;
            load = 1'b1;
            lsig = (op == sri_pkg::OP_LH);
            size = sri_pkg::SZ_HALF;
         end
         sri_pkg::OP_LW: begin
            wr   = 1'b1;
            dst  = rt;
            load = 1'b1;
            size = sri_pkg::SZ_WORD;
         end
         sri_pkg::OP_SB: begin
            store = 1'b1;
            size  = sri_pkg::SZ_BYTE;
         end
         sri_pkg::OP_SH: begin
            store = 1'b1;
            size  = sri_pkg::SZ_HALF;
         end
         sri_pkg::OP_SW: begin
            store = 1'b1;
            size  = sri_pkg::SZ_WORD;
         end
         default: ill = 1'b1;
      endcase
   end

   // register zero is never written
   always_comb begin
      ex             = '0;
      ex.wr          = wr && (dst != '0);
      ex.dst         = ex.wr ? dst : '0;
      ex.value       = ex.wr ? val : '0;
      ex.br          = br;
      ex.tgt         = br ? tgt : '0;
      ex.ill         = ill;
      ex.load        = load && ex.wr;
      ex.load_signed = lsig;
      ex.store       = store;
      ex.size        = size;
      ex.ea          = a + simm;
      ex.store_data  = b;
   end

endmodule

>>> tb/tb_scalar_risc_instruction_execute.sv
`timescale 1ns / 1ps
// self-checking testbench for scalar_risc_instruction_execute: directed and random requests
// with random idling on both channels, checked against an in-bench execute model
// depends on sri_pkg, sri_if and the block's rtl
module tb_scalar_risc_instruction_execute;
   import sri_pkg::*;

   localparam logic [5:0] OP_UNDEF  = 6'h3f;
   localparam logic [5:0] FN_UNDEF  = 6'h01;
   localparam logic [4:0] RI_UNDEF  = 5'h02;
   localparam logic [4:0] CP0_UNDEF = 5'h01;
   localparam int RANDOM_ITEMS = 1500;

   typedef struct packed {
      logic [31:0] word;
      logic [31:0] address;
      logic        drain;
   } instr_req_type;

   typedef struct packed {
      logic        writes;
      logic [4:0]  dest;
      logic [31:0] value;
      logic        taken;
      logic [31:0] target;
      logic        illegal;
   } retire_type;

   logic clock;
   logic reset = 1'b1;

   sri_req_if req_ch ();
   sri_rsp_if rsp_ch ();

   scalar_risc_instruction_execute u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   instr_req_type program_q[$];
   retire_type    expected_retires[$];
   logic [31:0] gpr[32];
   logic [7:0]  data_bytes[DATA_MEM_BYTES];
   int          error_count = 0;
   int unsigned idle_left = 0;
   int unsigned stall_left = 0;
   int unsigned send_idle_pct = 20;
   int unsigned recv_stall_pct = 20;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.instruction_word = '0;
      req_ch.instruction_address = '0;
      rsp_ch.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // big-endian byte access, wrapping at the memory size
   function automatic logic [31:0] read_bytes(logic [31:0] ea, int n);
      logic [31:0] v;
      logic [31:0] p;
      v = '0;
      for (int i = 0; i < n; i++) begin
         p = ea + i;
         v = {v[23:0], data_bytes[p % DATA_MEM_BYTES]};
      end
      return v;
   endfunction

   function automatic void write_bytes(logic [31:0] ea, logic [31:0] v, int n);
      logic [31:0] p;
      for (int i = 0; i < n; i++) begin
         p = ea + i;
         data_bytes[p % DATA_MEM_BYTES] = 8'(v >> (8 * (n - 1 - i)));
      end
   endfunction

   function automatic retire_type execute_instruction(logic [31:0] iw, logic [31:0] pc);
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sa;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] simm;
      logic [31:0] zimm;
      logic [31:0] ea;
      logic [31:0] btgt;
      logic [31:0] m;
      retire_type  r;
      op = iw[31:26];
      rs = iw[25:21];
      rt = iw[20:16];
      rd = iw[15:11];
      sa = iw[10:6];
      fn = iw[5:0];
      a = (rs == 5'd0) ? 32'd0 : gpr[rs];
      b = (rt == 5'd0) ? 32'd0 : gpr[rt];
      simm = {{16{iw[15]}}, iw[15:0]};
      zimm = {16'h0000, iw[15:0]};
      ea = a + simm;
      btgt = pc + (simm << 2) + 32'd4;
      r = '0;
      case (op)
         OP_SPECIAL: begin
            r.writes = 1'b1;
            r.dest = rd;
            case (fn)
               FN_SLL:  r.value = b << sa;
               FN_SRL:  r.value = b >> sa;
               FN_SRA:  r.value = $signed(b) >>> sa;
               FN_SLLV: r.value = b << a[4:0];
               FN_SRLV: r.value = b >> a[4:0];
               FN_SRAV: r.value = $signed(b) >>> a[4:0];
               FN_JR: begin
                  r.writes = 1'b0;
                  r.taken = 1'b1;
                  r.target = JR_BASE | (a & JR_MASK);
               end
               FN_JALR: begin
                  r.taken = 1'b1;
                  r.target = JR_BASE | (a & JR_MASK);
                  r.value = pc + 32'd8;
               end
               FN_BREAK: r.writes = 1'b0;
               FN_ADD, FN_ADDU: r.value = a + b;
               FN_SUB, FN_SUBU: r.value = a - b;
               FN_AND:  r.value = a & b;
               FN_OR:   r.value = a | b;
               FN_XOR:  r.value = a ^ b;
               FN_NOR:  r.value = ~(a | b);
               FN_SLT:  r.value = {31'd0, $signed(a) < $signed(b)};
               FN_SLTU: r.value = {31'd0, a < b};
               default: begin
                  r.writes = 1'b0;
                  r.illegal = 1'b1;
               end
            endcase
         end
         OP_REGIMM: begin
            case (rt)
               RI_BLTZ: r.taken = a[31];
               RI_BGEZ: r.taken = ~a[31];
               RI_BLTZAL: begin
                  r.taken = a[31];
                  r.writes = 1'b1;
                  r.dest = LINK_REG;
                  r.value = pc + 32'd8;
               end
               RI_BGEZAL: begin
                  r.taken = ~a[31];
                  r.writes = 1'b1;
                  r.dest = LINK_REG;
                  r.value = pc + 32'd8;
               end
               default: r.illegal = 1'b1;
            endcase
            r.target = btgt;
         end
         OP_J: begin
            r.taken = 1'b1;
            r.target = {4'h0, iw[25:0], 2'b00};
         end
         OP_JAL: begin
            r.taken = 1'b1;
            r.target = {4'h0, iw[25:0], 2'b00};
            r.writes = 1'b1;
            r.dest = LINK_REG;
            r.value = (pc + 32'd8) & LINK_MASK;
         end
         OP_BEQ: begin
            r.taken = (a == b);
            r.target = btgt;
         end
         OP_BNE: begin
            r.taken = (a != b);
            r.target = btgt;
         end
         OP_BLEZ: begin
            r.taken = (a == 32'd0) || a[31];
            r.target = btgt;
         end
         OP_BGTZ: begin
            r.taken = (a != 32'd0) && !a[31];
            r.target = btgt;
         end
         OP_ADDI, OP_ADDIU: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = a + simm;
         end
         OP_SLTI: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = {31'd0, $signed(a) < $signed(simm)};
         end
         OP_SLTIU: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = {31'd0, a < simm};
         end
         OP_ANDI: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = a & zimm;
         end
         OP_ORI: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = a | zimm;
         end
         OP_XORI: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = a ^ zimm;
         end
         OP_LUI: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = {iw[15:0], 16'h0000};
         end
         OP_COP0: begin
            if (rs != CP0_MF && rs != CP0_MT) r.illegal = 1'b1;
         end
         OP_COP2, OP_LWC2, OP_SWC2: ;
         OP_LB: begin
            m = read_bytes(ea, 1);
            r.writes = 1'b1;
            r.dest = rt;
            r.value = {{24{m[7]}}, m[7:0]};
         end
         OP_LH: begin
            m = read_bytes(ea, 2);
            r.writes = 1'b1;
            r.dest = rt;
            r.value = {{16{m[15]}}, m[15:0]};
         end
         OP_LW: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = read_bytes(ea, 4);
         end
         OP_LBU: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = read_bytes(ea, 1);
         end
         OP_LHU: begin
            r.writes = 1'b1;
            r.dest = rt;
            r.value = read_bytes(ea, 2);
         end
         OP_SB: write_bytes(ea, b, 1);
         OP_SH: write_bytes(ea, b, 2);
         OP_SW: write_bytes(ea, b, 4);
         default: r.illegal = 1'b1;
      endcase
      if (r.writes && r.dest == 5'd0) r.writes = 1'b0;
      if (r.writes) begin
         gpr[r.dest] = r.value;
      end else begin
         r.dest = '0;
         r.value = '0;
      end
      if (!r.taken) r.target = '0;
      return r;
   endfunction

   function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sa);
      return {OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] tgt);
      return {op, tgt};
   endfunction

   function automatic void add_request(logic [31:0] word, logic [31:0] address, logic drain);
      instr_req_type item;
      item.word = word;
      item.address = address;
      item.drain = drain;
      program_q.push_back(item);
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic int unsigned pick_idle_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 70;
      endcase
   endfunction

   // mostly a handful of registers so that results feed later requests
   function automatic logic [4:0] rand_reg();
      if ($urandom_range(0, 3) != 0) return 5'($urandom_range(0, 7));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [5:0] pick_op();
      case ($urandom_range(0, 29))
         0, 1, 2, 3: return OP_SPECIAL;
         4:  return OP_REGIMM;
         5:  return OP_J;
         6:  return OP_JAL;
         7:  return OP_BEQ;
         8:  return OP_BNE;
         9:  return OP_BLEZ;
         10: return OP_BGTZ;
         11: return OP_ADDI;
         12: return OP_ADDIU;
         13: return OP_SLTI;
         14: return OP_SLTIU;
         15: return OP_ANDI;
         16: return OP_ORI;
         17: return OP_XORI;
         18: return OP_LUI;
         19: return OP_LB;
         20: return OP_LH;
         21, 22: return OP_LW;
         23: return OP_LBU;
         24: return OP_LHU;
         25: return OP_SB;
         26: return OP_SH;
         default: return OP_SW;
      endcase
   endfunction

   function automatic logic [5:0] pick_funct();
      case ($urandom_range(0, 18))
         0:  return FN_SLL;
         1:  return FN_SRL;
         2:  return FN_SRA;
         3:  return FN_SLLV;
         4:  return FN_SRLV;
         5:  return FN_SRAV;
         6:  return FN_JR;
         7:  return FN_JALR;
         8:  return FN_BREAK;
         9:  return FN_ADD;
         10: return FN_ADDU;
         11: return FN_SUB;
         12: return FN_SUBU;
         13: return FN_AND;
         14: return FN_OR;
         15: return FN_XOR;
         16: return FN_NOR;
         17: return FN_SLT;
         default: return FN_SLTU;
      endcase
   endfunction

   function automatic logic [4:0] pick_regimm();
      case ($urandom_range(0, 3))
         0: return RI_BLTZ;
         1: return RI_BGEZ;
         2: return RI_BLTZAL;
         default: return RI_BGEZAL;
      endcase
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      logic [5:0]  op;
      w = $urandom();
      case ($urandom_range(0, 19))
         0, 1: ;
         2: w[31:21] = {OP_COP0, ($urandom_range(0, 1) != 0) ? CP0_MF : CP0_MT};
         3: w[31:26] = OP_COP0;
         4: begin
            case ($urandom_range(0, 2))
               0: w[31:26] = OP_COP2;
               1: w[31:26] = OP_LWC2;
               default: w[31:26] = OP_SWC2;
            endcase
         end
         5: begin
            w[31:26] = OP_SPECIAL;
            if ($urandom_range(0, 1) != 0) w[5:0] = FN_BREAK;
         end
         6: w[31:26] = OP_REGIMM;
         default: begin
            op = pick_op();
            w[31:26] = op;
            w[25:21] = rand_reg();
            w[20:16] = rand_reg();
            case (op)
               OP_SPECIAL: begin
                  w[15:11] = rand_reg();
                  w[5:0] = pick_funct();
               end
               OP_REGIMM: w[20:16] = pick_regimm();
               OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
                  // small window around address zero so loads see stored data
                  if ($urandom_range(0, 1) != 0) begin
                     w[25:21] = 5'd0;
                     w[15:0] = 16'($urandom_range(0, 47)) - 16'd8;
                  end
               end
               default: ;
            endcase
         end
      endcase
      return w;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : driver
      instr_req_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_retires.push_back(execute_instruction(req_ch.instruction_word,
                                                           req_ch.instruction_address));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_ch.valid <= 1'b0;
            end else if (program_q.size() != 0 &&
                         !(program_q[0].drain && expected_retires.size() != 0)) begin
               item = program_q.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.instruction_word <= item.word;
               req_ch.instruction_address <= item.address;
               if ($urandom_range(0, 99) == 0) send_idle_pct = pick_idle_pct();
               idle_left = ($urandom_range(0, 99) < send_idle_pct) ? idle_length() : 0;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      retire_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_retires.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_retires.pop_front();
               check_field("writes_register", 32'(want.writes),
                           32'(rsp_ch.writes_register));
               check_field("dest_register", 32'(want.dest), 32'(rsp_ch.dest_register));
               check_field("dest_value", want.value, rsp_ch.dest_value);
               check_field("branch_taken", 32'(want.taken), 32'(rsp_ch.branch_taken));
               check_field("branch_target", want.target, rsp_ch.branch_target);
               check_field("illegal_opcode", 32'(want.illegal),
                           32'(rsp_ch.illegal_opcode));
            end
         end
         if ($urandom_range(0, 199) == 0) recv_stall_pct = pick_idle_pct();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            stall_left = idle_length() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int          count;
      int unsigned r;
      logic [4:0]  rx;
      logic [4:0]  base;
      logic [15:0] imm;
      logic [31:0] v;
      logic [5:0]  st_op;
      logic [5:0]  ld_op;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (data_bytes[i]) data_bytes[i] = '0;

      // register extremes, shifts, compares, zero destination
      add_request(enc_i(OP_LUI, 0, 1, 16'h8000), 32'h0000_0000, 1'b0);
      add_request(enc_i(OP_ORI, 1, 1, 16'hffff), 32'h0000_0004, 1'b0);
      add_request(enc_i(OP_ADDIU, 0, 2, 16'hffff), 32'h0000_0008, 1'b0);
      add_request(enc_r(FN_SRA, 0, 1, 3, 5'd31), 32'h0000_000c, 1'b0);
      add_request(enc_r(FN_SLLV, 2, 2, 4, 5'd0), 32'h0000_0010, 1'b0);
      add_request(enc_r(FN_SLT, 1, 2, 5, 5'd0), 32'h0000_0014, 1'b0);
      add_request(enc_i(OP_SLTIU, 1, 6, 16'hffff), 32'h0000_0018, 1'b0);
      add_request(enc_i(OP_ADDI, 2, 0, 16'h0001), 32'h0000_001c, 1'b0);
      // accesses wrapping around the end of memory
      add_request(enc_i(OP_SW, 0, 1, 16'h0ffe), 32'h0000_0020, 1'b0);
      add_request(enc_i(OP_LB, 0, 7, 16'h0ffe), 32'h0000_0024, 1'b0);
      add_request(enc_i(OP_LH, 0, 8, 16'h0fff), 32'h0000_0028, 1'b0);
      add_request(enc_i(OP_LHU, 0, 9, 16'h0000), 32'h0000_002c, 1'b0);
      add_request(enc_i(OP_SB, 0, 2, 16'hffff), 32'h0000_0030, 1'b0);
      add_request(enc_i(OP_LW, 0, 10, 16'h0ffe), 32'h0000_0034, 1'b0);
      // branches, links and jumps at address extremes
      add_request(enc_i(OP_BEQ, 0, 0, 16'h8000), 32'h0000_0000, 1'b0);
      add_request(enc_i(OP_REGIMM, 1, RI_BGEZAL, 16'h7fff), 32'hffff_fff8, 1'b0);
      add_request(enc_i(OP_REGIMM, 1, RI_BLTZ, 16'h0001), 32'hffff_fffc, 1'b0);
      add_request(enc_i(OP_BGTZ, 6, 0, 16'h0004), 32'h8000_0000, 1'b0);
      add_request(enc_j(OP_J, 26'h3ff_ffff), 32'hffff_fffc, 1'b0);
      add_request(enc_j(OP_JAL, 26'h000_0000), 32'hffff_fff8, 1'b0);
      add_request(enc_r(FN_JALR, 2, 0, 11, 5'd0), 32'h7fff_fff0, 1'b0);
      add_request(enc_r(FN_JR, 1, 0, 0, 5'd0), 32'h0000_0040, 1'b0);
      // left-out and undefined encodings
      add_request(enc_r(FN_BREAK, 5'h1f, 5'h1f, 5'h1f, 5'h1f), 32'h0000_0044, 1'b0);
      add_request({OP_COP0, CP0_MT, 21'h1f_ffff}, 32'h0000_0048, 1'b0);
      add_request({OP_COP0, CP0_UNDEF, 21'h00_0000}, 32'h0000_004c, 1'b0);
      add_request({OP_LWC2, 26'h3ff_ffff}, 32'h0000_0050, 1'b0);
      add_request({OP_UNDEF, 26'h000_0000}, 32'h0000_0054, 1'b0);
      add_request(enc_r(FN_UNDEF, 1, 2, 3, 5'd0), 32'h0000_0058, 1'b0);
      add_request(enc_i(OP_REGIMM, 0, RI_UNDEF, 16'h0000), 32'h0000_005c, 1'b0);

      count = 0;
      while (count < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            // full 32-bit constant into a register
            rx = 5'($urandom_range(1, 7));
            v = $urandom();
            add_request(enc_i(OP_LUI, 0, rx, v[31:16]), $urandom(), count == 0);
            add_request(enc_i(OP_ORI, rx, rx, v[15:0]), $urandom(), 1'b0);
            count += 2;
         end else if (r < 22) begin
            // store followed by a load near the same address
            base = ($urandom_range(0, 1) != 0) ? 5'd0 : rand_reg();
            imm = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 63)) : 16'($urandom());
            case ($urandom_range(0, 2))
               0: st_op = OP_SB;
               1: st_op = OP_SH;
               default: st_op = OP_SW;
            endcase
            case ($urandom_range(0, 4))
               0: ld_op = OP_LB;
               1: ld_op = OP_LH;
               2: ld_op = OP_LW;
               3: ld_op = OP_LBU;
               default: ld_op = OP_LHU;
            endcase
            add_request(enc_i(st_op, base, rand_reg(), imm), $urandom(), count == 0);
            add_request(enc_i(ld_op, base, rand_reg(), imm + 16'($urandom_range(0, 3))),
                        $urandom(), 1'b0);
            count += 2;
         end else begin
            add_request(random_instruction(), $urandom(),
                        count == 0 || $urandom_range(0, 299) == 0);
            count++;
         end
      end

      while (program_q.size() != 0 || req_ch.valid || expected_retires.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_retires.size() != 0) begin
         $error("%0d responses never arrived", expected_retires.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
